/* src/subpixel_edgel_extractor_defines.svh */
// Assertion macros for the subpixel edgel extractor.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef SUBPIXEL_EDGEL_EXTRACTOR_DEFINES_SVH
`define SUBPIXEL_EDGEL_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SPE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("subpixel edgel extractor: assertion failed");

// Next-cycle implication, checked out of reset.
`define SPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("subpixel edgel extractor: assertion failed");

`endif

/* src/spe_pkg.sv */
// Shared types, constants and helpers of the subpixel edgel extractor.
// No dependencies; used by every module and interface of the block.
`timescale 1ns / 1ps
`default_nettype none

package spe_pkg;

  // Field widths
  localparam int STRENGTH_W = 16;
  localparam int ANGLE_W    = 16;
  localparam int OFFSET_W   = 14;
  localparam int POS_W      = 22;
  localparam int POS_FRAC   = 8;

  // Image size limits and configuration
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int SIZE_W     = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Trig format
  localparam int TRIG_FRAC_BITS = 14;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int TRIG_ONE       = 1 << TRIG_FRAC_BITS;
  localparam int ROUND_SHIFT    = 30 - TRIG_FRAC_BITS;
  localparam int DISP_SHIFT     = TRIG_FRAC_BITS + 12 - POS_FRAC;
  localparam int PROD_W         = TRIG_W + OFFSET_W;

  // Angle folding: 2^14 codes per quadrant
  localparam int QTR_BITS = 14;
  localparam int R_W      = QTR_BITS + 1;
  localparam int QUARTER  = 1 << QTR_BITS;

  // Q30 series constants and exact reciprocal multipliers
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [29:0] DIV9_MUL  = 30'd954437177;   // 2^33 / 9, rounded up
  localparam int          DIV9_SH   = 33;
  localparam logic [31:0] DIV21_MUL = 32'd3272356036;  // 2^36 / 21, rounded up
  localparam int          DIV21_SH  = 36;
  localparam logic [29:0] DIV5_MUL  = 30'd858993460;   // 2^32 / 5, rounded up
  localparam int          DIV5_SH   = 32;
  localparam logic [30:0] DIV3_MUL  = 31'd1431655766;  // 2^32 / 3, rounded up
  localparam int          DIV3_SH   = 32;

  // Pipeline stages
  localparam int STG_IN   = 0;
  localparam int STG_TRIG = 11;
  localparam int STG_PROD = 12;
  localparam int STG_OUT  = 13;
  localparam int DEPTH    = STG_OUT + 1;

  typedef struct packed {
    logic [R_W-1:0] r;
    logic           neg;
  } fold_t;

  typedef struct packed {
    logic [STRENGTH_W-1:0]      strength;
    logic signed [ANGLE_W-1:0]  angle;
    logic signed [OFFSET_W-1:0] offset;
    logic [COL_W-1:0]           col;
    logic [ROW_W-1:0]           row;
  } side_t;

  // Fold an angle code onto the first quadrant of the sine.
  function automatic fold_t fold_angle(input logic [ANGLE_W-1:0] code);
    fold_t               f;
    logic [QTR_BITS-1:0] low;
    low   = code[QTR_BITS-1:0];
    f.r   = code[QTR_BITS] ? (R_W'(QUARTER) - R_W'(low)) : R_W'(low);
    f.neg = code[QTR_BITS+1];
    return f;
  endfunction

endpackage

`default_nettype wire

/* src/spe_in_if.sv */
// Request channel of the subpixel edgel extractor: one pixel of the edge map.
// Depends on spe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spe_in_if;
  logic                                valid;
  logic                                ready;
  logic [spe_pkg::STRENGTH_W-1:0]      strength;
  logic signed [spe_pkg::ANGLE_W-1:0]  angle;
  logic signed [spe_pkg::OFFSET_W-1:0] offset;

  modport source (output valid, strength, angle, offset, input ready);
  modport sink   (input valid, strength, angle, offset, output ready);
endinterface

`default_nettype wire

/* src/spe_out_if.sv */
// Result channel of the subpixel edgel extractor: one edgel.
// Depends on spe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spe_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [spe_pkg::POS_W-1:0]   x_pos;
  logic signed [spe_pkg::POS_W-1:0]   y_pos;
  logic signed [spe_pkg::ANGLE_W-1:0] edge_angle;
  logic [spe_pkg::STRENGTH_W-1:0]     edge_strength;

  modport source (output valid, x_pos, y_pos, edge_angle, edge_strength, input ready);
  modport sink   (input valid, x_pos, y_pos, edge_angle, edge_strength, output ready);
endinterface

`default_nettype wire

/* src/spe_raster.sv */
// Image size registers and raster column/row counters.
// Depends on spe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spe_raster (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire spe_pkg::cfg_wr_t          cfg_i,
  input  wire logic                      adv_i,
  output logic [spe_pkg::COL_W-1:0]      col_o,
  output logic [spe_pkg::ROW_W-1:0]      row_o
);

  logic [spe_pkg::SIZE_W-1:0] width_q, height_q;
  logic [spe_pkg::SIZE_W-1:0] eff_w, eff_h;
  logic [spe_pkg::COL_W-1:0]  col_q, col_d;
  logic [spe_pkg::ROW_W-1:0]  row_q, row_d;
  logic [spe_pkg::COL_W:0]    col_inc;
  logic [spe_pkg::ROW_W:0]    row_inc;

  // Zero or oversize acts as the maximum.
  always_comb begin
    eff_w = (width_q == '0 || width_q > spe_pkg::SIZE_W'(spe_pkg::MAX_WIDTH)) ?
            spe_pkg::SIZE_W'(spe_pkg::MAX_WIDTH) : width_q;
    eff_h = (height_q == '0 || height_q > spe_pkg::SIZE_W'(spe_pkg::MAX_HEIGHT)) ?
            spe_pkg::SIZE_W'(spe_pkg::MAX_HEIGHT) : height_q;
  end

  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    col_d   = col_q;
    row_d   = row_q;
    if (adv_i) begin
      if (spe_pkg::SIZE_W'(col_inc) >= eff_w) begin
        col_d = '0;
        row_d = (spe_pkg::SIZE_W'(row_inc) >= eff_h) ? '0 : row_inc[spe_pkg::ROW_W-1:0];
      end else begin
        col_d = col_inc[spe_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= spe_pkg::WIDTH_RESET;
      height_q <= spe_pkg::HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_i.we) begin
        case (cfg_i.idx)
          spe_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
          spe_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

`default_nettype wire

/* src/spe_sine.sv */
// Sine lane: Q30 odd series of a folded angle, rounded to the trig format.
// Stages 1 to 11 of the block pipeline. Depends on spe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spe_sine (
  input  wire logic                           clk_i,
  input  wire logic [spe_pkg::DEPTH-1:0]      en_i,
  input  wire spe_pkg::fold_t                 fold_i,
  output logic signed [spe_pkg::TRIG_W-1:0]   trig_o
);

  logic [30:0] x_q  [1:9];
  logic [31:0] x2_q [2:7];
  logic        neg_q [1:10];
  logic [29:0] d3_q, d5_q, d7_q, d9_q;
  logic [31:0] p4_q, p6_q, p8_q, s10_q;
  logic signed [spe_pkg::TRIG_W-1:0] trig_q;

  logic [46:0] mul1;
  logic [61:0] mul2;
  logic [58:0] mul3;
  logic [30:0] t4, t6, t8, t10;
  logic [62:0] mul4, mul6, mul8;
  logic [62:0] mul5;
  logic [59:0] mul7;
  logic [61:0] mul9, mul10;
  logic [31:0] rnd;
  logic [spe_pkg::TRIG_W-1:0] mag;

  always_comb begin
    mul1 = 47'(fold_i.r) * 47'(spe_pkg::PI_Q30);
    mul2 = 62'(x_q[1]) * 62'(x_q[1]);
    mul3 = 59'(x2_q[2][31:3]) * 59'(spe_pkg::DIV9_MUL);
    t4   = spe_pkg::ONE_Q30 - 31'(d3_q);
    mul4 = 63'(x2_q[3]) * 63'(t4);
    mul5 = 63'(p4_q[31:1]) * 63'(spe_pkg::DIV21_MUL);
    t6   = spe_pkg::ONE_Q30 - 31'(d5_q);
    mul6 = 63'(x2_q[5]) * 63'(t6);
    mul7 = 60'(p6_q[31:2]) * 60'(spe_pkg::DIV5_MUL);
    t8   = spe_pkg::ONE_Q30 - 31'(d7_q);
    mul8 = 63'(x2_q[7]) * 63'(t8);
    mul9 = 62'(p8_q[31:1]) * 62'(spe_pkg::DIV3_MUL);
    t10  = spe_pkg::ONE_Q30 - 31'(d9_q);
    mul10 = 62'(x_q[9]) * 62'(t10);
    rnd  = s10_q + (32'd1 << (spe_pkg::ROUND_SHIFT - 1));
    mag  = spe_pkg::TRIG_W'(rnd >> spe_pkg::ROUND_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x_q[1]   <= mul1[45:15];
      neg_q[1] <= fold_i.neg;
    end
    for (int k = 2; k <= 9; k++) begin
      if (en_i[k]) x_q[k] <= x_q[k-1];
    end
    for (int k = 2; k <= 10; k++) begin
      if (en_i[k]) neg_q[k] <= neg_q[k-1];
    end
    if (en_i[2]) x2_q[2] <= mul2[61:30];
    for (int k = 3; k <= 7; k++) begin
      if (en_i[k]) x2_q[k] <= x2_q[k-1];
    end
    // Series terms: divide, then multiply by (one minus quotient).
    if (en_i[3])  d3_q  <= 30'(mul3 >> spe_pkg::DIV9_SH);
    if (en_i[4])  p4_q  <= mul4[61:30];
    if (en_i[5])  d5_q  <= 30'(mul5 >> spe_pkg::DIV21_SH);
    if (en_i[6])  p6_q  <= mul6[61:30];
    if (en_i[7])  d7_q  <= 30'(mul7 >> spe_pkg::DIV5_SH);
    if (en_i[8])  p8_q  <= mul8[61:30];
    if (en_i[9])  d9_q  <= 30'(mul9 >> spe_pkg::DIV3_SH);
    if (en_i[10]) s10_q <= mul10[61:30];
    if (en_i[spe_pkg::STG_TRIG]) trig_q <= neg_q[10] ? -$signed(mag) : $signed(mag);
  end

  assign trig_o = trig_q;

endmodule

`default_nettype wire

/* src/spe_place.sv */
// Edgel placement: trig times offset, rounded to 1/256 pixel, plus the counter.
// Stages 12 and 13 of the block pipeline. Depends on spe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spe_place (
  input  wire logic                             clk_i,
  input  wire logic [spe_pkg::DEPTH-1:0]        en_i,
  input  wire logic signed [spe_pkg::TRIG_W-1:0]   trig_c_i,
  input  wire logic signed [spe_pkg::TRIG_W-1:0]   trig_s_i,
  input  wire logic signed [spe_pkg::OFFSET_W-1:0] offset_i,
  input  wire logic [spe_pkg::COL_W-1:0]        col_i,
  input  wire logic [spe_pkg::ROW_W-1:0]        row_i,
  output logic signed [spe_pkg::POS_W-1:0]      x_pos_o,
  output logic signed [spe_pkg::POS_W-1:0]      y_pos_o
);

  logic signed [spe_pkg::PROD_W-1:0] prod_x_q, prod_y_q;
  logic signed [spe_pkg::POS_W-1:0]  x_pos_q, y_pos_q;

  // Round half up to 1/256 pixel and add the whole-pixel counter.
  function automatic logic [spe_pkg::POS_W-1:0] place_pos(
    input logic signed [spe_pkg::PROD_W-1:0] prod,
    input logic [spe_pkg::COL_W-1:0]         cnt
  );
    logic signed [spe_pkg::PROD_W-1:0] biased;
    logic signed [spe_pkg::PROD_W-1:0] disp;
    biased = prod + (spe_pkg::PROD_W'(1) <<< (spe_pkg::DISP_SHIFT - 1));
    disp   = biased >>> spe_pkg::DISP_SHIFT;
    return spe_pkg::POS_W'({cnt, spe_pkg::POS_FRAC'(0)}) + spe_pkg::POS_W'(disp);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[spe_pkg::STG_PROD]) begin
      prod_x_q <= spe_pkg::PROD_W'(trig_c_i) * spe_pkg::PROD_W'(offset_i);
      prod_y_q <= spe_pkg::PROD_W'(trig_s_i) * spe_pkg::PROD_W'(offset_i);
    end
    if (en_i[spe_pkg::STG_OUT]) begin
      x_pos_q <= $signed(place_pos(prod_x_q, col_i));
      y_pos_q <= $signed(place_pos(prod_y_q, spe_pkg::COL_W'(row_i)));
    end
  end

  assign x_pos_o = x_pos_q;
  assign y_pos_o = y_pos_q;

endmodule

`default_nettype wire

/* src/subpixel_edgel_extractor.sv */
// Top level of the subpixel edgel extractor: request register, sine lanes,
// placement and result register. Depends on spe_pkg, spe_in_if, spe_out_if.
`timescale 1ns / 1ps
`default_nettype none

// Turns an edge-detector map, one pixel per request in raster order, into
// edgels. Each request carries strength, gradient angle and subpixel offset;
// the column and row counters advance on every accepted request and wrap at
// the configured image size (0 or above 4096 means 4096). A request with
// nonzero strength yields one edgel at column/row plus cos/sin of the angle
// times the offset, in 1/256 pixel, with angle and strength passed through;
// a zero-strength request yields nothing. The block takes one request per
// clock while ready is high and delivers results in order. The pipeline depth
// is set by the sine series: a multiply for the scaled angle, one for its
// square, three for the series terms and one for the final product, with four
// reciprocal-multiply divides between them, each with its own register; then
// one stage to round and sign the trig value and two for the offset product
// and the final add, 14 stages in all counting the request register. Every
// stage holds its own valid bit and moves up whenever a later stage has a
// gap, so requests keep being taken while a finished edgel waits at the
// output; ready drops only when all 14 stages are full and the result is
// stalled. Zero-strength requests enter as gaps. Write image_width and
// image_height only while idle.

`include "subpixel_edgel_extractor_defines.svh"

module subpixel_edgel_extractor (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [spe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [spe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  spe_in_if.sink                               req_i,
  spe_out_if.source                            res_o
);

  logic [spe_pkg::DEPTH-1:0]  v_q;
  logic [spe_pkg::DEPTH-1:0]  en;
  logic                       accept;
  spe_pkg::cfg_wr_t           cfg;
  logic [spe_pkg::COL_W-1:0]  col;
  logic [spe_pkg::ROW_W-1:0]  row;
  spe_pkg::side_t             side_q [0:spe_pkg::STG_OUT];
  spe_pkg::fold_t             fold_s_q, fold_c_q;
  logic signed [spe_pkg::TRIG_W-1:0] trig_s, trig_c;
  logic signed [spe_pkg::POS_W-1:0]  x_pos, y_pos;
  logic                       trig_ok;

  // A stage may load when it is empty or some later stage has a gap, or the
  // result is being taken.
  always_comb begin
    for (int k = 0; k < spe_pkg::DEPTH; k++) begin
      en[k] = res_o.ready ||
              !(&(v_q | spe_pkg::DEPTH'((1 << k) - 1)));
    end
  end

  assign req_i.ready = en[spe_pkg::STG_IN];
  assign accept      = req_i.valid && en[spe_pkg::STG_IN];

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  spe_raster u_raster (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .adv_i  (accept),
    .col_o  (col),
    .row_o  (row)
  );

  // Valid bits; a zero-strength request enters as a gap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[spe_pkg::STG_IN]) begin
        v_q[spe_pkg::STG_IN] <= req_i.valid && (req_i.strength != '0);
      end
      for (int k = 1; k < spe_pkg::DEPTH; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Request register and the side data that rides along the pipeline.
  always_ff @(posedge clk_i) begin
    if (en[spe_pkg::STG_IN]) begin
      side_q[spe_pkg::STG_IN].strength <= req_i.strength;
      side_q[spe_pkg::STG_IN].angle    <= req_i.angle;
      side_q[spe_pkg::STG_IN].offset   <= req_i.offset;
      side_q[spe_pkg::STG_IN].col      <= col;
      side_q[spe_pkg::STG_IN].row      <= row;
      fold_s_q <= spe_pkg::fold_angle(req_i.angle);
      fold_c_q <= spe_pkg::fold_angle(req_i.angle + spe_pkg::ANGLE_W'(spe_pkg::QUARTER));
    end
    for (int k = 1; k < spe_pkg::DEPTH; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  spe_sine u_sine (
    .clk_i  (clk_i),
    .en_i   (en),
    .fold_i (fold_s_q),
    .trig_o (trig_s)
  );

  spe_sine u_cosine (
    .clk_i  (clk_i),
    .en_i   (en),
    .fold_i (fold_c_q),
    .trig_o (trig_c)
  );

  // Offset comes from the trig stage, counters from the product stage.
  spe_place u_place (
    .clk_i    (clk_i),
    .en_i     (en),
    .trig_c_i (trig_c),
    .trig_s_i (trig_s),
    .offset_i (side_q[spe_pkg::STG_TRIG].offset),
    .col_i    (side_q[spe_pkg::STG_PROD].col),
    .row_i    (side_q[spe_pkg::STG_PROD].row),
    .x_pos_o  (x_pos),
    .y_pos_o  (y_pos)
  );

  assign res_o.valid         = v_q[spe_pkg::STG_OUT];
  assign res_o.x_pos         = x_pos;
  assign res_o.y_pos         = y_pos;
  assign res_o.edge_angle    = side_q[spe_pkg::STG_OUT].angle;
  assign res_o.edge_strength = side_q[spe_pkg::STG_OUT].strength;

  // Both trig values stay within plus or minus one.
  assign trig_ok = (trig_s <= spe_pkg::TRIG_ONE) && (trig_s >= -spe_pkg::TRIG_ONE) &&
                   (trig_c <= spe_pkg::TRIG_ONE) && (trig_c >= -spe_pkg::TRIG_ONE);

  `SPE_ASSERT_IMPL(a_full_when_blocked, !req_i.ready, (&v_q) && !res_o.ready)
  `SPE_ASSERT_NEXT(a_edge_captured, accept && (req_i.strength != '0), v_q[spe_pkg::STG_IN])
  `SPE_ASSERT_IMPL(a_edgel_nonzero, res_o.valid, res_o.edge_strength != '0)
  `SPE_ASSERT_IMPL(a_trig_range, v_q[spe_pkg::STG_TRIG], trig_ok)

endmodule

`default_nettype wire

/* bench/subpixel_edgel_extractor_checker.sv */
`timescale 1ns / 1ps
// Result checker for the subpixel edgel extractor: follows configuration
// writes and pixel requests, predicts each edgel and compares it in order.
// Depends on spe_pkg, spe_in_if and spe_out_if.

module subpixel_edgel_extractor_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [spe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [spe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  spe_in_if                                   pixel_ch,
  spe_out_if                                  edgel_ch,
  output int                                  fail_count_o,
  output int                                  outstanding_o
);
  import spe_pkg::*;

  localparam int              SIZE_LIMIT   = 4096;
  localparam int              TRIG_BITS    = 14;
  localparam int              DISP_DROP    = TRIG_BITS + 4;
  localparam longint unsigned PI_SCALED    = 64'd3373259426;
  localparam longint unsigned UNIT_SCALED  = 64'd1 << 30;

  typedef struct packed {
    logic [POS_W-1:0]      x_pos;
    logic [POS_W-1:0]      y_pos;
    logic [ANGLE_W-1:0]    angle;
    logic [STRENGTH_W-1:0] strength;
  } edgel_t;

  edgel_t          pending_edgels[$];
  edgel_t          due;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  int unsigned     col_at;
  int unsigned     row_at;
  int              mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns edgel mismatch: %s", $time, what);
  endtask

  // First-quadrant sine, r in 0..16384, rounded to TRIG_BITS fraction bits.
  function automatic longint unsigned sine_magnitude(input int unsigned r);
    longint unsigned x, x2, t, s;
    x  = (64'(r) * PI_SCALED) >> 15;
    x2 = (x * x) >> 30;
    t  = UNIT_SCALED - x2 / 72;
    t  = UNIT_SCALED - ((x2 * t) >> 30) / 42;
    t  = UNIT_SCALED - ((x2 * t) >> 30) / 20;
    t  = UNIT_SCALED - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    return (s + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
  endfunction

  function automatic longint signed_sine(input logic [ANGLE_W-1:0] code);
    int unsigned r;
    longint      mag;
    r = int'(code[13:0]);
    if (code[14]) r = 16384 - r;
    mag = longint'(sine_magnitude(r));
    return code[15] ? -mag : mag;
  endfunction

  // Counter in whole pixels plus rounded trig * offset, wrapped to the field.
  function automatic logic [POS_W-1:0] edgel_coord(input int unsigned counter,
                                                   input longint trig,
                                                   input longint offset);
    longint disp, pos;
    disp = (trig * offset + (longint'(1) <<< (DISP_DROP - 1))) >>> DISP_DROP;
    pos  = longint'(counter) * 256 + disp;
    return pos[POS_W-1:0];
  endfunction

  function automatic int unsigned span_of(input logic [SIZE_W-1:0] v);
    return (v == '0 || int'(v) > SIZE_LIMIT) ? SIZE_LIMIT : int'(v);
  endfunction

  function automatic edgel_t predict_edgel(input logic [STRENGTH_W-1:0] strength,
                                          input logic [ANGLE_W-1:0] angle,
                                          input logic signed [OFFSET_W-1:0] offset);
    edgel_t e;
    logic [ANGLE_W-1:0] cos_code;
    cos_code   = angle + 16'd16384;
    e.x_pos    = edgel_coord(col_at, signed_sine(cos_code), longint'(offset));
    e.y_pos    = edgel_coord(row_at, signed_sine(angle), longint'(offset));
    e.angle    = angle;
    e.strength = strength;
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = 13'd640;
      height_reg = 13'd480;
      col_at     = 0;
      row_at     = 0;
      pending_edgels.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IMAGE_WIDTH) width_reg = cfg_data_i;
        else if (cfg_idx_i == CFG_IMAGE_HEIGHT) height_reg = cfg_data_i;
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (pixel_ch.strength != '0)
          pending_edgels = {pending_edgels,
                            predict_edgel(pixel_ch.strength, pixel_ch.angle,
                                          pixel_ch.offset)};
        col_at++;
        if (col_at >= span_of(width_reg)) begin
          col_at = 0;
          row_at++;
          if (row_at >= span_of(height_reg)) row_at = 0;
        end
      end
      if (edgel_ch.valid && edgel_ch.ready) begin
        if (pending_edgels.size() == 0) begin
          report_mismatch("edgel delivered with none expected");
        end else begin
          due = pending_edgels.pop_front();
          if (edgel_ch.x_pos !== due.x_pos)
            report_mismatch($sformatf("x_pos got %h want %h", edgel_ch.x_pos, due.x_pos));
          if (edgel_ch.y_pos !== due.y_pos)
            report_mismatch($sformatf("y_pos got %h want %h", edgel_ch.y_pos, due.y_pos));
          if (edgel_ch.edge_angle !== due.angle)
            report_mismatch($sformatf("edge_angle got %h want %h",
                                      edgel_ch.edge_angle, due.angle));
          if (edgel_ch.edge_strength !== due.strength)
            report_mismatch($sformatf("edge_strength got %h want %h",
                                      edgel_ch.edge_strength, due.strength));
        end
      end
    end
    outstanding_o = pending_edgels.size();
  end

endmodule

/* bench/subpixel_edgel_extractor_tb.sv */
`timescale 1ns / 1ps
// Testbench top of the subpixel edgel extractor: clock, reset, pixel stimulus,
// result back-pressure and verdict. Depends on spe_pkg, both channel
// interfaces, subpixel_edgel_extractor and subpixel_edgel_extractor_checker.

module subpixel_edgel_extractor_tb;
  import spe_pkg::*;

  // Pipeline is 14 stages deep; allow a good margin before reconfiguring
  localparam int     SETTLE_CYCLES = 32;
  // Far beyond the slowest legal run (every request gapped and stalled)
  localparam longint RUN_LIMIT_NS  = 64'd3_000_000;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    outstanding;
  bit                    idling = 1'b0;

  spe_in_if  pixel_ch ();
  spe_out_if edgel_ch ();

  subpixel_edgel_extractor DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (pixel_ch),
    .res_o      (edgel_ch)
  );

  subpixel_edgel_extractor_checker edgel_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_ch      (pixel_ch),
    .edgel_ch      (edgel_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Present one pixel request and hold it until the block takes it. Called
  // and returning at a falling edge; valid stays high into the next request
  // unless a gap is inserted, so it is never dropped and raised in one step.
  task automatic send_pixel(input logic [STRENGTH_W-1:0] strength,
                            input logic [ANGLE_W-1:0] angle,
                            input logic [OFFSET_W-1:0] offset);
    if (idling && $urandom_range(0, 3) == 0) begin
      pixel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    pixel_ch.valid    <= 1'b1;
    pixel_ch.strength <= strength;
    pixel_ch.angle    <= angle;
    pixel_ch.offset   <= offset;
    do @(posedge clk_i); while (!pixel_ch.ready);
    @(negedge clk_i);
  endtask

  // Random pixels; blank_pct of them carry no edge. Bias the fields towards
  // their extremes and the quadrant boundaries of the angle.
  task automatic send_random(input int unsigned count, input int unsigned blank_pct);
    logic [STRENGTH_W-1:0] strength;
    logic [ANGLE_W-1:0]    angle;
    logic [OFFSET_W-1:0]   offset;
    repeat (count) begin
      if ($urandom_range(0, 99) < blank_pct) strength = '0;
      else begin
        case ($urandom_range(0, 7))
          0:       strength = 16'd1;
          1:       strength = 16'hFFFF;
          default: strength = 16'($urandom_range(1, 65535));
        endcase
      end
      case ($urandom_range(0, 5))
        0:       angle = 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
        1:       angle = 16'($urandom_range(0, 7) << 13);
        default: angle = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       offset = 14'h2000;
        1:       offset = 14'h1FFF;
        2:       offset = 14'h0000;
        default: offset = 14'($urandom);
      endcase
      send_pixel(strength, angle, offset);
    end
  endtask

  // Hold off requests until every predicted edgel is out, then let the
  // pipeline run empty in case trailing blank pixels are still inside.
  task automatic settle_pipeline();
    pixel_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write both size registers on consecutive edges; enable stays high across
  // the pair so it is assigned once per step.
  task automatic set_size(input logic [SIZE_W-1:0] width, input logic [SIZE_W-1:0] height);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IMAGE_WIDTH;
    cfg_data_i <= width;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_IMAGE_HEIGHT;
    cfg_data_i <= height;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Result side: while idling is on, mix ready bursts and stall bursts at random;
  // otherwise keep ready high.
  initial begin : edgel_sink
    int unsigned span;
    edgel_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idling && $urandom_range(0, 2) == 0) begin
        edgel_ch.ready <= 1'b0;
        span = $urandom_range(1, 6);
      end else begin
        edgel_ch.ready <= 1'b1;
        span = $urandom_range(1, 10);
      end
      repeat (span - 1) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_IMAGE_WIDTH;
    cfg_data_i        <= '0;
    pixel_ch.valid    <= 1'b0;
    pixel_ch.strength <= '0;
    pixel_ch.angle    <= '0;
    pixel_ch.offset   <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    idling = 1'b1;

    // Directed pixels at the reset size of 640 x 480: blank pixels, extreme
    // strengths, the four axis angles and their neighbours, extreme offsets.
    send_pixel(16'd0,     16'h0000, 14'h0000);
    send_pixel(16'd1,     16'h0000, 14'h1FFF);
    send_pixel(16'hFFFF,  16'h4000, 14'h2000);
    send_pixel(16'h8000,  16'h8000, 14'h1FFF);
    send_pixel(16'd123,   16'h7FFF, 14'h2000);
    send_pixel(16'd7,     16'hC000, 14'h1000);
    send_pixel(16'd300,   16'h2000, 14'h3FFF);
    send_pixel(16'd301,   16'hE000, 14'h0001);
    send_pixel(16'd1,     16'h3FFF, 14'h1FFF);
    send_pixel(16'd2,     16'hFFFF, 14'h2000);
    send_pixel(16'd0,     16'h3039, 14'h3FFF);
    send_pixel(16'hFFFF,  16'h6000, 14'h0800);
    send_pixel(16'd2,     16'hA000, 14'h3800);
    send_pixel(16'd40000, 16'h0001, 14'h0000);
    send_pixel(16'h5555,  16'h4001, 14'h2AAA);
    send_pixel(16'hAAAA,  16'hBFFF, 14'h1555);
    send_pixel(16'd0,     16'hFFFF, 14'h1FFF);
    send_pixel(16'd9,     16'h8001, 14'h2001);
    send_pixel(16'd10,    16'hC001, 14'h1FFE);
    send_pixel(16'hFFFE,  16'h4000, 14'h1FFF);

    // One pixel per line and per frame: counters wrap on every request, and
    // the column left over from the default size is used once as it stands.
    settle_pipeline();
    set_size(13'd1, 13'd1);
    send_random(120, 20);

    // Largest legal size
    settle_pipeline();
    set_size(13'd4096, 13'd4096);
    send_random(120, 20);

    // Shrink well below the current column counter mid-frame
    settle_pipeline();
    set_size(13'd3, 13'd2);
    send_random(120, 20);

    // Zero reads as the maximum; run this stretch without any idling
    settle_pipeline();
    idling = 1'b0;
    set_size(13'd0, 13'd0);
    send_random(120, 20);

    // One column and a zero height: the column wraps on every request and
    // the row counter climbs with every request.
    settle_pipeline();
    idling = 1'b1;
    set_size(13'd1, 13'd0);
    send_random(200, 50);

    // Zero width and one row: the column counter climbs along a single line
    settle_pipeline();
    set_size(13'd0, 13'd1);
    send_random(200, 50);

    // Values above the maximum, all bits of the register set
    settle_pipeline();
    set_size(13'h1FFF, 13'd4097);
    send_random(120, 20);

    // Random small frames and one fully random size
    repeat (4) begin
      settle_pipeline();
      set_size(13'($urandom_range(1, 40)), 13'($urandom_range(1, 12)));
      send_random(60, 20);
    end
    settle_pipeline();
    set_size(13'($urandom), 13'($urandom));
    send_random(80, 20);

    // Closing stretch at full rate on both sides
    settle_pipeline();
    idling = 1'b0;
    set_size(13'd5, 13'd4);
    send_random(120, 20);

    settle_pipeline();
    if (fail_count == 0) begin
      $display("subpixel_edgel_extractor verification clean");
    end else begin
      $display("subpixel_edgel_extractor verification failed");
    end
    $finish;
  end

  // Hard stop should the block hang or drop an edgel
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("subpixel_edgel_extractor verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/spe_pkg.sv
src/spe_in_if.sv
src/spe_out_if.sv
src/spe_raster.sv
src/spe_sine.sv
src/spe_place.sv
src/subpixel_edgel_extractor.sv
bench/subpixel_edgel_extractor_checker.sv
bench/subpixel_edgel_extractor_tb.sv
